FILE: rtl/tcet_pkg.sv
// Shared types and constants for the transaction conflict edge tracker.
// No dependencies; imported by txn_conflict_edge_tracker, tcet_front and tcet_back.
`default_nettype none
package tcet_pkg;
   localparam int ID_W    = 10;   // txn id and tuple index width
   localparam int THR_W   = 6;    // abort threshold width
   localparam int ENTRY_W = ID_W + 1;
   localparam logic [THR_W-1:0] THR_RESET = 6'd63;

   localparam logic [1:0] ST_EDGE     = 2'd0;
   localparam logic [1:0] ST_RECORDED = 2'd1;
   localparam logic [1:0] ST_ABORTED  = 2'd2;
   localparam logic [1:0] ST_SKIPPED  = 2'd3;

   localparam logic [1:0] DEP_WAR = 2'd0;
   localparam logic [1:0] DEP_WAW = 2'd1;
   localparam logic [1:0] DEP_RAW = 2'd2;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] from_txn;
      logic [ID_W-1:0] to_txn;
      logic [1:0]      dep_kind;
      logic            last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: rtl/txn_conflict_edge_tracker.sv
// Flow: an accepted request passes the front (accept, reciprocal multiply, push) and the
//   queue; the back reads the abort flag and history length, then gives an abort or skip
//   result, or walks the len history entries of a recorded access (max 63) and appends it.
// The front takes a new request only after pushing the last one into the queue. The back
//   does one history memory read per cycle; a stalled output holds the walk at the next edge.
// Reset: synchronous; afterwards a clearing pass zeroes the abort flags and history
//   lengths before the back part pops the first request from the queue.
`default_nettype none
module txn_conflict_edge_tracker
   import tcet_pkg::*;
#(
   parameter int NUM_TXNS   = 1024,
   parameter int NUM_TUPLES = 1024,
   parameter int HIST_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [23:0]       req_tdata,   // txn_id[9:0], tuple_index[19:10], is_write[20]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,   // from_txn[9:0], to_txn[19:10], dep_kind[21:20]
   output logic [1:0]             rsp_tuser,   // status[1:0]
   output logic                   rsp_tlast,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [THR_W-1:0]  csr_data     // abort_threshold
);
   localparam int TS_W  = $clog2(NUM_TXNS);
   localparam int TP_W  = $clog2(NUM_TUPLES);
   localparam int ACC_W = ID_W + 1 + TS_W + TP_W;

   logic [THR_W-1:0] thr_ff;
   logic             q_push, q_full, q_pop, q_valid;
   logic [ACC_W-1:0] q_in, q_out;
   rsp_type          rsp;

   // threshold register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          thr_ff <= THR_RESET;
      else if (csr_valid) thr_ff <= csr_data;
   end

   // front: take request, reduce ids to slots
   tcet_front #(.NUM_TXNS(NUM_TXNS), .NUM_TUPLES(NUM_TUPLES)) u_front (
      .clock, .reset,
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_txn   (req_tdata[9:0]),
      .in_tuple (req_tdata[19:10]),
      .in_write (req_tdata[20]),
      .q_push, .q_data(q_in), .q_full
   );

   // decouples front from the history walk
   tcet_queue #(.W(ACC_W)) u_queue (
      .clock, .reset,
      .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
   );

   // back: abort check, history walk, append, output register
   tcet_back #(
      .NUM_TXNS(NUM_TXNS), .NUM_TUPLES(NUM_TUPLES), .HIST_DEPTH(HIST_DEPTH)
   ) u_back (
      .clock, .reset,
      .threshold(thr_ff),
      .q_valid, .q_data(q_out), .q_pop,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp
   );

   assign rsp_tdata = {2'b00, rsp.dep_kind, rsp.to_txn, rsp.from_txn};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;
endmodule
`default_nettype wire

FILE: rtl/tcet_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on nothing.
`default_nettype none
module tcet_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output logic [W-1:0]      pop_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) begin
            mem_ff[wp_ff] <= push_data;
            wp_ff         <= ~wp_ff;
         end
         if (pop && not_empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tcet_front.sv
// Front part: takes requests and reduces txn id and tuple index to their slots.
// Uses tcet_pkg; feeds tcet_queue.
`default_nettype none
module tcet_front
   import tcet_pkg::*;
#(
   parameter int NUM_TXNS   = 1024,
   parameter int NUM_TUPLES = 1024,
   localparam int TS_W  = $clog2(NUM_TXNS),
   localparam int TP_W  = $clog2(NUM_TUPLES),
   localparam int ACC_W = ID_W + 1 + TS_W + TP_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [ID_W-1:0]  in_txn,
   input  wire logic [ID_W-1:0]  in_tuple,
   input  wire logic             in_write,
   output logic                  q_push,
   output logic [ACC_W-1:0]      q_data,
   input  wire logic             q_full
);
   // floor(x / N) == (x * MUL) >> SH for every ID_W-bit x, MUL = ceil(2^SH / N)
   localparam int     PROD_W = 2 * ID_W + 2;
   localparam int     T_SH   = ID_W + TS_W;
   localparam int     P_SH   = ID_W + TP_W;
   localparam longint T_MUL  = ((longint'(1) << T_SH) + longint'(NUM_TXNS) - 1) /
                               longint'(NUM_TXNS);
   localparam longint P_MUL  = ((longint'(1) << P_SH) + longint'(NUM_TUPLES) - 1) /
                               longint'(NUM_TUPLES);
   // divisor low bits; remainder math is done modulo 2^ID_W
   localparam logic [ID_W-1:0] T_MOD = ID_W'(NUM_TXNS);
   localparam logic [ID_W-1:0] P_MOD = ID_W'(NUM_TUPLES);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_type;

   fstate_type        state_ff;
   logic [ID_W-1:0]   txn_ff, tup_ff;
   logic              wr_ff;
   logic [ID_W-1:0]   txn_quo_ff, tup_quo_ff, txn_quo_in, tup_quo_in;
   logic [PROD_W-1:0] txn_prod, tup_prod;
   logic [ID_W-1:0]   txn_rem, tup_rem;

   always_comb begin
      txn_prod   = {(ID_W+2)'(0), txn_ff} * PROD_W'(T_MUL);
      tup_prod   = {(ID_W+2)'(0), tup_ff} * PROD_W'(P_MUL);
      txn_quo_in = ID_W'(txn_prod >> T_SH);
      tup_quo_in = ID_W'(tup_prod >> P_SH);
      txn_rem    = txn_ff - ID_W'(txn_quo_ff * T_MOD);
      tup_rem    = tup_ff - ID_W'(tup_quo_ff * P_MOD);
   end

   assign in_ready = (state_ff == F_IDLE);
   assign q_push   = (state_ff == F_PUSH) && !q_full;
   assign q_data   = {txn_ff, wr_ff, TS_W'(txn_rem), TP_W'(tup_rem)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (in_valid) begin
                  txn_ff   <= in_txn;
                  tup_ff   <= in_tuple;
                  wr_ff    <= in_write;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               txn_quo_ff <= txn_quo_in;
               tup_quo_ff <= tup_quo_in;
               state_ff   <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tcet_back.sv
// Back part: abort table, history lengths and history entries; walks history
// and emits results. Uses tcet_pkg; pops tcet_queue.
`default_nettype none
module tcet_back
   import tcet_pkg::*;
#(
   parameter int NUM_TXNS   = 1024,
   parameter int NUM_TUPLES = 1024,
   parameter int HIST_DEPTH = 64,
   localparam int TS_W  = $clog2(NUM_TXNS),
   localparam int TP_W  = $clog2(NUM_TUPLES),
   localparam int ACC_W = ID_W + 1 + TS_W + TP_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [THR_W-1:0]  threshold,
   input  wire logic              q_valid,
   input  wire logic [ACC_W-1:0]  q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp
);
   localparam int LEN_W  = $clog2(HIST_DEPTH + 1);
   localparam int ENT_N  = NUM_TUPLES * HIST_DEPTH;
   localparam int ENT_AW = $clog2(ENT_N);
   localparam int CLR_N  = (NUM_TXNS > NUM_TUPLES) ? NUM_TXNS : NUM_TUPLES;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam int CMP_W  = LEN_W + THR_W;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOKUP, S_WALK, S_FLUSH} state_type;

   logic             ab_mem  [NUM_TXNS];
   logic [LEN_W-1:0] len_mem [NUM_TUPLES];
   logic [ENTRY_W-1:0] ent_mem [ENT_N];

   state_type          state_ff;
   logic [CLR_W-1:0]   clr_ff;
   logic [ID_W-1:0]    txn_ff;
   logic               wr_ff;
   logic [TS_W-1:0]    tslot_ff;
   logic [TP_W-1:0]    tup_ff;
   logic [LEN_W-1:0]   len_ff, k_ff;
   logic               pend_v_ff;
   logic [ID_W-1:0]    pend_to_ff;
   logic [1:0]         pend_kind_ff;
   logic               rsp_v_ff;
   rsp_type            rsp_ff;
   logic               ab_rd_ff;
   logic [LEN_W-1:0]   len_rd_ff;
   logic [ENTRY_W-1:0] ent_rd_ff;

   logic [ID_W-1:0]    q_txn;
   logic               q_wr;
   logic [TS_W-1:0]    q_tslot;
   logic [TP_W-1:0]    q_tup;
   logic               out_free, conflict, adv, over, rsp_load;
   logic [ID_W-1:0]    owner;
   logic               ewr;
   logic [1:0]         kind;
   logic [TS_W-1:0]    ab_raddr;
   logic [TP_W-1:0]    len_raddr;
   logic [LEN_W-1:0]   ent_idx;
   logic [ENT_AW-1:0]  ent_base, ent_raddr, ent_waddr;

   assign {q_txn, q_wr, q_tslot, q_tup} = q_data;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      out_free  = !rsp_v_ff || rsp_ready;
      owner     = ent_rd_ff[ENTRY_W-1:1];
      ewr       = ent_rd_ff[0];
      conflict  = (owner != txn_ff) && (wr_ff || ewr);
      kind      = !wr_ff ? DEP_RAW : (ewr ? DEP_WAW : DEP_WAR);
      // a further edge needs the output slot for the held one
      adv       = !(conflict && pend_v_ff && !out_free);
      over      = (CMP_W'(len_rd_ff) > CMP_W'(threshold)) ||
                  (len_rd_ff >= LEN_W'(HIST_DEPTH));
      // output register takes a new result this cycle
      rsp_load  = ((state_ff == S_LOOKUP) && (ab_rd_ff || over) && out_free) ||
                  ((state_ff == S_WALK) && adv && conflict && pend_v_ff) ||
                  ((state_ff == S_FLUSH) && out_free);
      ab_raddr  = (state_ff == S_IDLE) ? q_tslot : tslot_ff;
      len_raddr = (state_ff == S_IDLE) ? q_tup : tup_ff;
      ent_base  = ENT_AW'(tup_ff) * ENT_AW'(HIST_DEPTH);
      if (state_ff == S_LOOKUP) ent_idx = len_rd_ff - 1'b1;
      else if (adv)             ent_idx = k_ff - LEN_W'(2);
      else                      ent_idx = k_ff - 1'b1;
      ent_raddr = ent_base + ENT_AW'(ent_idx);
      ent_waddr = ent_base + ENT_AW'(len_ff);
   end

   // memories: registered reads, single write port each
   always_ff @(posedge clock) begin
      ab_rd_ff  <= ab_mem[ab_raddr];
      len_rd_ff <= len_mem[len_raddr];
      ent_rd_ff <= ent_mem[ent_raddr];
      if (state_ff == S_CLEAR) begin
         if (clr_ff < CLR_W'(NUM_TXNS - 1) || clr_ff == CLR_W'(NUM_TXNS - 1))
            ab_mem[TS_W'(clr_ff)] <= 1'b0;
         if (clr_ff < CLR_W'(NUM_TUPLES - 1) || clr_ff == CLR_W'(NUM_TUPLES - 1))
            len_mem[TP_W'(clr_ff)] <= '0;
      end else begin
         if (state_ff == S_LOOKUP && !ab_rd_ff && over && out_free)
            ab_mem[tslot_ff] <= 1'b1;
         if (state_ff == S_FLUSH && out_free) begin
            len_mem[tup_ff]    <= len_ff + 1'b1;
            ent_mem[ent_waddr] <= {txn_ff, wr_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_load || (rsp_v_ff && !rsp_ready);
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(CLR_N - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_valid) begin
                  txn_ff   <= q_txn;
                  wr_ff    <= q_wr;
                  tslot_ff <= q_tslot;
                  tup_ff   <= q_tup;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               len_ff    <= len_rd_ff;
               k_ff      <= len_rd_ff;
               pend_v_ff <= 1'b0;
               if (ab_rd_ff || over) begin
                  if (out_free) begin
                     rsp_ff   <= '{status: ab_rd_ff ? ST_SKIPPED : ST_ABORTED,
                                   from_txn: txn_ff, to_txn: '0, dep_kind: DEP_WAR,
                                   last: 1'b1};
                     state_ff <= S_IDLE;
                  end
               end else if (len_rd_ff == '0) begin
                  state_ff <= S_FLUSH;
               end else begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (adv) begin
                  if (conflict) begin
                     if (pend_v_ff) begin
                        rsp_ff   <= '{status: ST_EDGE, from_txn: txn_ff,
                                      to_txn: pend_to_ff, dep_kind: pend_kind_ff,
                                      last: 1'b0};
                     end
                     pend_v_ff    <= 1'b1;
                     pend_to_ff   <= owner;
                     pend_kind_ff <= kind;
                  end
                  k_ff <= k_ff - 1'b1;
                  if (k_ff == LEN_W'(1)) state_ff <= S_FLUSH;
               end
            end
            S_FLUSH: begin
               if (out_free) begin
                  if (pend_v_ff)
                     rsp_ff <= '{status: ST_EDGE, from_txn: txn_ff, to_txn: pend_to_ff,
                                 dep_kind: pend_kind_ff, last: 1'b1};
                  else
                     rsp_ff <= '{status: ST_RECORDED, from_txn: txn_ff, to_txn: '0,
                                 dep_kind: DEP_WAR, last: 1'b1};
                  pend_v_ff <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !q_pop) else $error("pop during clearing pass");
   a_walk_k: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> k_ff != '0) else $error("walk with empty count");
   a_nonedge_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.status != ST_EDGE |-> rsp_ff.to_txn == '0 && rsp_ff.last)
      else $error("non-edge result malformed");
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_v_ff) else $error("held edge left over");
`endif
endmodule
`default_nettype wire

FILE: dv/txn_conflict_edge_tracker_tb.sv
// Self-checking testbench for txn_conflict_edge_tracker: drives access requests,
// predicts dependency edge, recorded, abort and skip results and checks them in order.
// Depends on rtl/tcet_pkg.sv and rtl/txn_conflict_edge_tracker.sv.
`timescale 1ns / 100ps
`default_nettype none

module txn_conflict_edge_tracker_tb;
   import tcet_pkg::*;

   localparam int N_TXNS     = 1024;
   localparam int TUPLE_CNT  = 1024;
   localparam int HIST_MAX   = 64;
   localparam int IDLE_LIMIT = 20000;   // covers clearing pass and longest stalls

   // One predicted or observed result.
   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] from_txn;
      logic [ID_W-1:0] to_txn;
      logic [1:0]      dep_kind;
      logic            last;
   } edge_rsp_type;

   // Conflict predictor plus queue of pending expected results.
   class conflict_board;
      bit              abort_flag[N_TXNS];
      int unsigned     hist_len[TUPLE_CNT];
      logic [ENTRY_W-1:0] hist[TUPLE_CNT][HIST_MAX];
      logic [THR_W-1:0] threshold;
      edge_rsp_type    pending[$];
      int              errors;

      function void clear();
         foreach (abort_flag[i]) abort_flag[i] = 0;
         foreach (hist_len[i]) hist_len[i] = 0;
         threshold = THR_RESET;
         pending.delete();
         errors = 0;
      endfunction

      function void note_access(logic [ID_W-1:0] txn, logic [ID_W-1:0] tup, logic wr);
         edge_rsp_type r;
         int unsigned len;
         int n;
         logic [ID_W-1:0] owner;
         n = 0;
         r = '0;
         r.from_txn = txn;
         r.last = 1'b1;
         if (abort_flag[txn % N_TXNS]) begin
            r.status = ST_SKIPPED;
            pending = {pending, r};
            return;
         end
         len = hist_len[tup % TUPLE_CNT];
         if (len > threshold || len >= HIST_MAX) begin
            abort_flag[txn % N_TXNS] = 1;
            r.status = ST_ABORTED;
            pending = {pending, r};
            return;
         end
         // walk newest to oldest; own entries never conflict
         for (int k = int'(len) - 1; k >= 0; k--) begin
            owner = hist[tup][k][ENTRY_W-1:1];
            if (owner == txn) continue;
            if (!wr && !hist[tup][k][0]) continue;
            r = '0;
            r.status = ST_EDGE;
            r.from_txn = txn;
            r.to_txn = owner;
            r.dep_kind = !wr ? DEP_RAW : (hist[tup][k][0] ? DEP_WAW : DEP_WAR);
            pending = {pending, r};
            n++;
         end
         hist[tup][len] = {txn, wr};
         hist_len[tup] = len + 1;
         if (n == 0) begin
            r = '0;
            r.status = ST_RECORDED;
            r.from_txn = txn;
            r.last = 1'b1;
            pending = {pending, r};
         end else
            pending[$].last = 1'b1;
      endfunction

      function void check_result(edge_rsp_type got);
         edge_rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result %p", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
         if (got.from_txn !== exp.from_txn) begin
            $error("from_txn exp %0d got %0d", exp.from_txn, got.from_txn); errors++;
         end
         if (got.to_txn !== exp.to_txn) begin
            $error("to_txn exp %0d got %0d", exp.to_txn, got.to_txn); errors++;
         end
         if (got.dep_kind !== exp.dep_kind) begin
            $error("dep_kind exp %0d got %0d", exp.dep_kind, got.dep_kind); errors++;
         end
         if (got.last !== exp.last) begin
            $error("last exp %0d got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;   // txn_id[9:0], tuple_index[19:10], is_write[20]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [23:0]       rsp_tdata;   // from_txn[9:0], to_txn[19:10], dep_kind[21:20]
   logic [1:0]        rsp_tuser;   // status[1:0]
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [THR_W-1:0]  csr_data;    // abort_threshold

   conflict_board board;
   int  idle_cycles;
   int  stall_mode;     // receiver stall pattern selector
   int  gap_max;        // sender gap bound for the current phase
   int  txn_base;       // keeps phases on fresh transaction ids

   txn_conflict_edge_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result monitor and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      edge_rsp_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tuser;
            got.from_txn = rsp_tdata[9:0];
            got.to_txn   = rsp_tdata[19:10];
            got.dep_kind = rsp_tdata[21:20];
            got.last     = rsp_tlast;
            board.check_result(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver stall pattern, changed at the falling edge.
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
   end

   task automatic send_access(int txn, int tup, bit wr);
      // random gap before the request, sometimes none for back-to-back bursts
      if (gap_max > 0 && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, wr, tup[9:0], txn[9:0]};
      do @(posedge clock); while (!req_tready);
      board.note_access(txn[9:0], tup[9:0], wr);
      @(negedge clock);
   endtask

   // Let the pipeline drain before touching the threshold.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_threshold(int value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value[THR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      board.threshold = value[THR_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random transactional phase: eight live txns hammering n_tup tuples, one access in ten random.
   task automatic random_phase(int count, int n_tup);
      int tup_base;
      tup_base = $urandom_range(0, TUPLE_CNT - n_tup);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_access($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1));
         else
            send_access(txn_base + $urandom_range(0, 7),
                        tup_base + $urandom_range(0, n_tup - 1), $urandom_range(0, 1));
         if ((i % 12) == 11) begin
            gap_max = $urandom_range(0, 6);
            stall_mode = $urandom_range(0, 3);
         end
      end
      txn_base = (txn_base + 8) % 1000;
   endtask

   initial begin
      board = new();
      board.clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_tready = 1'b0;
      stall_mode = 0;
      gap_max = 0;
      txn_base = 16;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every dependency kind, own-access filter.
      send_access(0, 0, 0);          // first access, recorded
      send_access(1023, 0, 1);       // WAR vs txn 0
      send_access(0, 0, 1);          // WAW vs 1023, own read skipped
      send_access(5, 0, 0);          // RAW vs 0 and 1023
      send_access(5, 0, 0);          // same again, own entries no edge
      send_access(1023, 1023, 1);    // max tuple index
      send_access(7, 1023, 1);       // WAW
      send_access(8, 1023, 0);       // RAW newest first
      send_access(9, 1023, 1);       // WAR then WAW
      send_access(682, 341, 1);      // alternating bit patterns
      send_access(341, 682, 0);

      // Threshold 0: second access to a tuple aborts, later accesses by an aborted txn are skipped.
      write_threshold(0);
      send_access(100, 500, 1);
      send_access(101, 500, 0);      // aborted now
      send_access(101, 501, 0);      // skipped
      send_access(100, 500, 0);      // tuple already over threshold: aborted
      send_access(100, 502, 1);      // skipped

      // Maximum threshold: long histories with many edges.
      write_threshold(63);
      stall_mode = 1;
      for (int i = 0; i < 64; i++)
         send_access(200 + i, 900, i[0]);
      send_access(300, 900, 1);      // history full: aborted

      // Random phases across several thresholds.
      write_threshold(3);
      random_phase(40, 4);
      write_threshold(42);
      random_phase(35, 3);
      write_threshold(1);
      random_phase(35, 6);
      write_threshold(63);
      random_phase(30, 2);

      drain();
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
